/* design/tacho_period_rpm_meter_assert.svh */
// Assertion macros for the tachometer period-to-RPM meter.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef TACHO_PERIOD_RPM_METER_ASSERT_SVH
`define TACHO_PERIOD_RPM_METER_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define TPRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only.
`define TPRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tprm_pkg.sv */
// Package for the tachometer period-to-RPM meter: register codes, widths,
// handshake structs of the shared divider and the prescaler decode.
// No dependencies.
package tprm_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PRESCALE  = 2'd0,
    REG_CLOCK_HZ  = 2'd1,
    REG_MAX_SPEED = 2'd2
  } cfg_reg_e;

  localparam int unsigned PSC_W   = 2;
  localparam int unsigned CLK_W   = 27;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_W   = CLK_W;

  // Seconds per minute and the numerator width: 27 bits times 60
  localparam int unsigned MINUTE_S = 60;
  localparam int unsigned SIXTY_W  = 6;
  localparam int unsigned NUM_W    = CLK_W + SIXTY_W;

  // Widest prescaler shift and the width of a shift amount
  localparam int unsigned PSC_MAX_SH = 8;
  localparam int unsigned SH_W       = 4;

  localparam logic [PSC_W-1:0]   PSC_RST       = 2'd3;
  localparam logic [CLK_W-1:0]   CLOCK_HZ_RST  = 27'd39812000;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd5000;

  // Shared divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Prescaler code to left-shift amount
  function automatic logic [SH_W-1:0] prescale_shift(input logic [PSC_W-1:0] code);
    logic [SH_W-1:0] sh;
    case (code)
      2'd3:    sh = 4'd8;
      2'd2:    sh = 4'd6;
      2'd1:    sh = 4'd3;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

/* design/tprm_div.sv */
// Radix-2 restoring divider shared by the tachometer meter, one quotient bit
// per cycle. Depends on tprm_pkg (divider handshake structs).
module tprm_div #(
  parameter int unsigned NUM_W = 33,
  parameter int unsigned DEN_W = 28
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tprm_pkg::div_ctl_t  ctl_i,
  input  logic [NUM_W-1:0]    dividend_i,
  input  logic [DEN_W-1:0]    divisor_i,
  output tprm_pkg::div_sts_t  sts_o,
  output logic [NUM_W-1:0]    quotient_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } div_state_e;

  div_state_e         state_q;
  logic [STEP_W-1:0]  step_q;
  logic [NUM_W-1:0]   dvd_q;   // dividend shifts out, quotient shifts in
  logic [DEN_W-1:0]   rem_q;
  logic [DEN_W-1:0]   dsr_q;
  logic               done_q;

  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               fits;
  logic [DEN_W-1:0]   rem_d;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial = {rem_q, dvd_q[NUM_W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
    rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= '0;
      dvd_q   <= '0;
      rem_q   <= '0;
      dsr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (ctl_i.start) begin
            dvd_q   <= dividend_i;
            dsr_q   <= divisor_i;
            rem_q   <= '0;
            step_q  <= STEP_W'(NUM_W);
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q  <= rem_d;
          dvd_q  <= {dvd_q[NUM_W-2:0], fits};
          step_q <= step_q - 1'b1;
          if (step_q == STEP_W'(1)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign sts_o.busy  = (state_q == D_RUN);
  assign sts_o.done  = done_q;
  assign quotient_o  = dvd_q;

endmodule

/* design/tacho_period_rpm_meter.sv */
// Top level of the tachometer period-to-RPM meter: item sequencer, state,
// configuration registers and output word. Depends on tprm_pkg, tprm_div
// and tacho_period_rpm_meter_assert.svh.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_stall_o    | req_type_i, timer_value_i
//  out     | output    | out_valid_o / out_stall_i  | speed_rpm_o, valid_count_o,
//          |           |                            | compare_value_o, timeout_armed_o
//  cfg     | input     | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// A pulse that yields a speed goes from acceptance to the output register
// through S_MUL, which forms numerator and denominator, S_LOAD, which starts
// the divider, S_WAIT, where the shared divider gives one quotient bit per
// cycle and the speed is stored, and S_DONE, which loads the output word.
// Timeouts, first pulses after rest and zero differences go straight to
// S_DONE and reach the output register from there.
// in_stall_o is high from acceptance until the result is loaded; a stalled
// output word holds, and a new word waits in the sequencer until it is taken.
// Reset is asynchronous and needs no clearing pass.
`include "tacho_period_rpm_meter_assert.svh"

module tacho_period_rpm_meter #(
  parameter int unsigned TIMER_BITS     = 16,
  parameter int unsigned PULSES_PER_REV = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [tprm_pkg::CFG_W-1:0]           cfg_data_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [TIMER_BITS-1:0]                timer_value_i,
  // output words
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [tprm_pkg::SPEED_W-1:0]         speed_rpm_o,
  output logic [tprm_pkg::CNT_W-1:0]           valid_count_o,
  output logic [TIMER_BITS-1:0]                compare_value_o,
  output logic                                 timeout_armed_o
);

  localparam int unsigned NUM_W = tprm_pkg::NUM_W;
  localparam int unsigned SCL_W = TIMER_BITS + tprm_pkg::PSC_MAX_SH;
  localparam int unsigned DEN_W = SCL_W + $clog2(PULSES_PER_REV + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_WAIT,
    S_DONE
  } seq_state_e;

  seq_state_e                      state_q;

  // configuration
  logic [tprm_pkg::PSC_W-1:0]      prescale_q;
  logic [tprm_pkg::CLK_W-1:0]      clock_hz_q;
  logic [tprm_pkg::SPEED_W-1:0]    max_speed_q;

  // meter state
  logic [TIMER_BITS-1:0]           last_cap_q;
  logic [tprm_pkg::SPEED_W-1:0]    speed_q;
  logic [tprm_pkg::CNT_W-1:0]      accept_cnt_q;
  logic                            armed_q;
  logic [TIMER_BITS-1:0]           compare_q;

  // operands
  logic [SCL_W-1:0]                scaled_q;
  logic [NUM_W-1:0]                num_q;
  logic [DEN_W-1:0]                den_q;

  // output word
  logic                            out_valid_q;
  logic [tprm_pkg::SPEED_W-1:0]    out_speed_q;
  logic [tprm_pkg::CNT_W-1:0]      out_cnt_q;
  logic [TIMER_BITS-1:0]           out_cmp_q;
  logic                            out_armed_q;

  logic                            in_acc;
  logic                            out_free;
  logic [TIMER_BITS-1:0]           ticks;
  logic [TIMER_BITS-1:0]           cap_cmp;
  logic                            at_rest;
  logic [NUM_W-1:0]                quot;
  logic                            rpm_ok;
  tprm_pkg::div_ctl_t              div_ctl;
  tprm_pkg::div_sts_t              div_sts;

  // Handshake and pulse decode
  always_comb begin
    in_acc   = in_valid_i && !in_stall_o;
    out_free = !out_valid_q || !out_stall_i;
    ticks    = timer_value_i - last_cap_q;
    cap_cmp  = (timer_value_i == TIMER_BITS'(1)) ? '1 : (timer_value_i - 1'b1);
    at_rest  = (speed_q == '0) && (last_cap_q == '0);
    rpm_ok   = (quot < NUM_W'(max_speed_q));
    div_ctl.start = (state_q == S_LOAD);
  end

  assign in_stall_o = (state_q != S_IDLE);

  tprm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .sts_o      (div_sts),
    .quotient_o (quot)
  );

  // Sequencer, state, configuration and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prescale_q   <= tprm_pkg::PSC_RST;
      clock_hz_q   <= tprm_pkg::CLOCK_HZ_RST;
      max_speed_q  <= tprm_pkg::MAX_SPEED_RST;
      last_cap_q   <= '0;
      speed_q      <= '0;
      accept_cnt_q <= '0;
      armed_q      <= 1'b1;
      compare_q    <= '1;
      scaled_q     <= '0;
      num_q        <= '0;
      den_q        <= '0;
      out_valid_q  <= 1'b0;
      out_speed_q  <= '0;
      out_cnt_q    <= '0;
      out_cmp_q    <= '0;
      out_armed_q  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tprm_pkg::REG_PRESCALE:  prescale_q  <= cfg_data_i[tprm_pkg::PSC_W-1:0];
          tprm_pkg::REG_CLOCK_HZ:  clock_hz_q  <= cfg_data_i[tprm_pkg::CLK_W-1:0];
          tprm_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data_i[tprm_pkg::SPEED_W-1:0];
          default: ;
        endcase
      end

      // output word leaves; a word loaded this cycle takes its place
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_DONE;
            if (req_type_i) begin
              // timeout: stop the motor if armed
              if (armed_q) begin
                speed_q    <= '0;
                last_cap_q <= '0;
                armed_q    <= 1'b0;
              end
            end else begin
              last_cap_q <= timer_value_i;
              compare_q  <= cap_cmp;
              if (at_rest) begin
                armed_q <= 1'b1;
              end else if (ticks != '0) begin
                scaled_q <= SCL_W'(ticks) << tprm_pkg::prescale_shift(prescale_q);
                state_q  <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          num_q   <= NUM_W'(clock_hz_q) * NUM_W'(tprm_pkg::MINUTE_S);
          den_q   <= DEN_W'(scaled_q) * DEN_W'(PULSES_PER_REV);
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (div_sts.done) begin
            if (rpm_ok) begin
              speed_q      <= quot[tprm_pkg::SPEED_W-1:0];
              accept_cnt_q <= accept_cnt_q + 1'b1;
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_speed_q <= speed_q;
            out_cnt_q   <= accept_cnt_q;
            out_cmp_q   <= compare_q;
            out_armed_q <= armed_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign speed_rpm_o     = out_speed_q;
  assign valid_count_o   = out_cnt_q;
  assign compare_value_o = out_cmp_q;
  assign timeout_armed_o = out_armed_q;

  // Checks
  `TPRM_ASSERT_NOW(a_div_start_idle, (state_q == S_LOAD), (!div_sts.busy && den_q != '0), "divider started while busy or with zero divisor")
  `TPRM_ASSERT_NOW(a_div_done_wait, div_sts.done, (state_q == S_WAIT), "divider finished outside the wait state")
  `TPRM_ASSERT_NEXT(a_cnt_step, 1'b1, (accept_cnt_q == $past(accept_cnt_q) || accept_cnt_q == $past(accept_cnt_q) + 1'b1), "valid count moved by more than one")
  `TPRM_ASSERT_NOW(a_disarm_timeout, $fell(armed_q), $past(in_acc && req_type_i), "timeout disarmed without an accepted timeout")
  `TPRM_ASSERT_NEXT(a_speed_limit, (state_q == S_WAIT && div_sts.done && rpm_ok), (speed_q < max_speed_q), "stored speed not below the limit")

endmodule
